[rtl/qpd_pkg.sv]
// ----------------------------------------------------------------------------
// qpd_pkg
// Shared types and constants of the quoted-printable decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package qpd_pkg;

    // most results that one input item can cause
    localparam int RES_MAX = 3;
    // width of a result slot index and of a result count (0 to RES_MAX)
    localparam int RES_W   = 2;

    // one decoded result item
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
    } t_res;

endpackage

`default_nettype wire

[rtl/qpd_decode.sv]
// ----------------------------------------------------------------------------
// qpd_decode
// Escape scanner: holds the pending '=' lookahead and turns one input byte
// into zero to three result items.
// ----------------------------------------------------------------------------
`default_nettype none

module qpd_decode (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_take,
    input  wire logic [7:0]                i_byte,
    input  wire logic                      i_eom,
    output qpd_pkg::t_res                  o_res [qpd_pkg::RES_MAX],
    output logic [qpd_pkg::RES_W-1:0]      o_cnt
);
    import qpd_pkg::*;

    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UA10  = 8'h37;   // 'A' - 10
    localparam logic [7:0] CH_LA10  = 8'h57;   // 'a' - 10

    // lookahead depth held between items
    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_EQ   = 2'd1;
    localparam logic [1:0] PEND_TWO  = 2'd2;

    // hex digit check, returns {is_digit, value}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'h00;
            if (c >= 8'h30 && c <= 8'h39) begin
                d = c - CH_ZERO;
                hex_val = {1'b1, d[3:0]};
            end else if (c >= 8'h41 && c <= 8'h46) begin
                d = c - CH_UA10;
                hex_val = {1'b1, d[3:0]};
            end else if (c >= 8'h61 && c <= 8'h66) begin
                d = c - CH_LA10;
                hex_val = {1'b1, d[3:0]};
            end else begin
                hex_val = 5'd0;
            end
        end
    endfunction

    // underscore maps to space, all else copied
    function automatic logic [7:0] plain(input logic [7:0] c);
        plain = (c == CH_UNDER) ? CH_SPACE : c;
    endfunction

    logic [1:0]     r_pend_cnt;
    logic [7:0]     r_pend_byte;
    logic [1:0]     n_pend_cnt;
    logic [7:0]     n_pend_byte;
    logic [RES_W-1:0] n_num;
    logic [4:0]     hex_hi;
    logic [4:0]     hex_lo;
    t_res           res [RES_MAX];

    assign hex_hi = hex_val(r_pend_byte);
    assign hex_lo = hex_val(i_byte);

    // scan one byte against the pending escape and append results in order
    always_comb begin
        n_num       = '0;
        n_pend_cnt  = r_pend_cnt;
        n_pend_byte = r_pend_byte;
        for (int k = 0; k < RES_MAX; k++) begin
            res[k] = '0;
        end

        case (r_pend_cnt)
            PEND_EQ: begin
                n_pend_byte = i_byte;
                n_pend_cnt  = PEND_TWO;
            end
            PEND_TWO: begin
                n_pend_cnt  = PEND_NONE;
                n_pend_byte = 8'h00;
                if (hex_hi[4] && hex_lo[4]) begin
                    res[n_num] = '{data: {hex_hi[3:0], hex_lo[3:0]}, valid: 1'b1, last: 1'b0};
                    n_num      = n_num + 1'b1;
                end else if (r_pend_byte == CH_CR && i_byte == CH_LF) begin
                    // soft line break gives nothing
                    n_num = n_num;
                end else begin
                    // broken escape: literal '=', then rescan both bytes
                    res[n_num] = '{data: CH_EQ, valid: 1'b1, last: 1'b0};
                    n_num      = n_num + 1'b1;
                    if (r_pend_byte == CH_EQ) begin
                        n_pend_cnt  = PEND_TWO;
                        n_pend_byte = i_byte;
                    end else begin
                        res[n_num] = '{data: plain(r_pend_byte), valid: 1'b1, last: 1'b0};
                        n_num      = n_num + 1'b1;
                        if (i_byte == CH_EQ) begin
                            n_pend_cnt = PEND_EQ;
                        end else begin
                            res[n_num] = '{data: plain(i_byte), valid: 1'b1, last: 1'b0};
                            n_num      = n_num + 1'b1;
                        end
                    end
                end
            end
            default: begin
                if (i_byte == CH_EQ) begin
                    n_pend_cnt = PEND_EQ;
                end else begin
                    res[n_num] = '{data: plain(i_byte), valid: 1'b1, last: 1'b0};
                    n_num      = n_num + 1'b1;
                end
            end
        endcase

        // message end flushes the lookahead, adds an empty marker if there is no result, and marks the final result
        if (i_eom) begin
            if (n_pend_cnt != PEND_NONE) begin
                res[n_num] = '{data: CH_EQ, valid: 1'b1, last: 1'b0};
                n_num      = n_num + 1'b1;
            end
            if (n_pend_cnt == PEND_TWO) begin
                res[n_num] = '{data: plain(n_pend_byte), valid: 1'b1, last: 1'b0};
                n_num      = n_num + 1'b1;
            end
            if (n_num == '0) begin
                res[n_num] = '{data: 8'h00, valid: 1'b0, last: 1'b0};
                n_num      = n_num + 1'b1;
            end
            res[n_num - 1'b1].last = 1'b1;
            n_pend_cnt  = PEND_NONE;
            n_pend_byte = 8'h00;
        end
    end

    // lookahead state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_cnt  <= PEND_NONE;
            r_pend_byte <= 8'h00;
        end else if (i_take) begin
            r_pend_cnt  <= n_pend_cnt;
            r_pend_byte <= n_pend_byte;
        end
    end

    assign o_res = res;
    assign o_cnt = n_num;

endmodule

`default_nettype wire

[rtl/qpd_out_buf.sv]
// ----------------------------------------------------------------------------
// qpd_out_buf
// Result register: holds the results of one item and hands them out one
// per cycle on the output stream while the receiver is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module qpd_out_buf (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_load,
    input  wire qpd_pkg::t_res             i_res [qpd_pkg::RES_MAX],
    input  wire logic [qpd_pkg::RES_W-1:0] i_cnt,
    output logic                           o_free,
    output logic                           o_tvalid,
    input  wire logic                      i_tready,
    output qpd_pkg::t_res                  o_head
);
    import qpd_pkg::*;

    t_res             r_res [RES_MAX];
    logic [RES_W-1:0] r_cnt;
    logic [RES_W-1:0] r_idx;
    logic [RES_W-1:0] rem;

    // results still to be delivered
    assign rem      = r_cnt - r_idx;
    assign o_tvalid = (rem != '0);
    assign o_free   = (rem == '0) || ((rem == RES_W'(1)) && i_tready);
    assign o_head   = r_res[r_idx];

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    // fill count and read pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (i_load) begin
            r_cnt <= i_cnt;
            r_idx <= '0;
        end else if (o_tvalid && i_tready) begin
            r_idx <= r_idx + 1'b1;
        end
    end

endmodule

`default_nettype wire

[rtl/quoted_printable_decoder.sv]
// ----------------------------------------------------------------------------
// quoted_printable_decoder
// Streaming quoted-printable / Q-encoding decoder, one encoded byte per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one encoded byte per item in s_tdata, s_tlast on the
//   final byte of a message. Output stream m_*: one decoded byte per item in
//   m_tdata, m_tuser high when the byte is real (low only for an empty end
//   marker), m_tlast on the final result of each message.
//   Each accepted byte goes into an input register and is decoded in one
//   pass into the result register, from which its results show on m_*.
//   Throughput is one byte per cycle while each byte gives at most one
//   result and the receiver is ready; a byte that gives two or three results
//   (a broken escape, or the flush of held lookahead at message end) holds
//   the result register until all its results are out, and the input
//   register fills behind it.
//   s_tready is high while the input register is empty or its byte moves on
//   in this cycle; it drops while earlier results still wait beyond this
//   cycle, from a multi-result byte or a receiver stall, and during reset.
//   Synchronous active-low reset empties both registers and clears the
//   pending escape; the first item may arrive in the cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module quoted_printable_decoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic       s_tlast,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tuser,   // [0] byte_valid
    output logic            m_tlast
);
    import qpd_pkg::*;

    logic             r_in_vld;
    logic [7:0]       r_in_byte;
    logic             r_in_last;
    logic             buf_free;
    logic             take;
    t_res             dec_res [RES_MAX];
    logic [RES_W-1:0] dec_cnt;
    t_res             head;

    // input register moves on when the result register can take its results
    assign take     = r_in_vld && buf_free;
    assign s_tready = i_rst_n && (!r_in_vld || take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_tready) begin
            r_in_vld <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in_byte <= s_tdata;
            r_in_last <= s_tlast;
        end
    end

    // escape scanner
    qpd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (r_in_byte),
        .i_eom   (r_in_last),
        .o_res   (dec_res),
        .o_cnt   (dec_cnt)
    );

    // result register and serializer
    qpd_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (take),
        .i_res    (dec_res),
        .i_cnt    (dec_cnt),
        .o_free   (buf_free),
        .o_tvalid (m_tvalid),
        .i_tready (m_tready),
        .o_head   (head)
    );

    assign m_tdata = head.data;
    assign m_tuser = head.valid;
    assign m_tlast = head.last;

`ifndef SYNTHESIS
    // input side stalls only behind waiting results
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // an empty end marker always closes a message
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tuser) |-> m_tlast)
        else $error("empty result not marked last");

    // a taken message-end item always leaves something to deliver
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && r_in_last) |=> m_tvalid)
        else $error("message end produced no result");
`endif

endmodule

`default_nettype wire

[tb/tb_quoted_printable_decoder.sv]
// ----------------------------------------------------------------------------
// tb_quoted_printable_decoder
// Self-checking bench for the quoted-printable stream decoder. Encoded bytes
// go in as messages; a scoreboard decodes each accepted item on its own and
// checks every decoded item that leaves the block, in order.
// ----------------------------------------------------------------------------

class qp_scoreboard;

    qpd_pkg::t_res expected_bytes[$];
    logic [7:0]    held_bytes[2];
    int unsigned   held_count;
    int unsigned   step_count;
    int unsigned   errors;

    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    function new();
        held_count    = 0;
        held_bytes[0] = '0;
        held_bytes[1] = '0;
        errors        = 0;
    endfunction

    // push one decoded item, at most three per input item
    function void push_decoded(logic [7:0] d, logic v);
        qpd_pkg::t_res r;
        if (step_count >= qpd_pkg::RES_MAX) return;
        r.data  = d;
        r.valid = v;
        r.last  = 1'b0;
        expected_bytes.push_back(r);
        step_count++;
    endfunction

    // nibble value of a hex digit, -1 when not one
    function int hex_nibble(logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        return -1;
    endfunction

    function logic [7:0] plain_byte(logic [7:0] c);
        return (c == CH_UNDER) ? CH_SPACE : c;
    endfunction

    // byte with no escape waiting, or with a bare '=' waiting
    function void take_simple(logic [7:0] b);
        if (held_count == 0) begin
            if (b == CH_EQ) begin
                held_bytes[0] = b;
                held_count    = 1;
            end else begin
                push_decoded(plain_byte(b), 1'b1);
            end
        end else begin
            held_bytes[1] = b;
            held_count    = 2;
        end
    endfunction

    // predicted decoder step for one accepted encoded item
    function void note_encoded_byte(logic [7:0] b, logic eom);
        logic [7:0] first;
        int         hi;
        int         lo;
        step_count = 0;
        if (held_count < 2) begin
            take_simple(b);
        end else begin
            first         = held_bytes[1];
            hi            = hex_nibble(first);
            lo            = hex_nibble(b);
            held_count    = 0;
            held_bytes[0] = '0;
            held_bytes[1] = '0;
            if (hi >= 0 && lo >= 0) begin
                push_decoded(8'((hi << 4) | lo), 1'b1);
            end else if (!(first == CH_CR && b == CH_LF)) begin
                // broken escape: literal '=', then rescan both bytes
                push_decoded(CH_EQ, 1'b1);
                take_simple(first);
                take_simple(b);
            end
        end
        if (eom) begin
            // flush of a short escape at message end, an empty marker if nothing came, and the last mark
            if (held_count >= 1) push_decoded(CH_EQ, 1'b1);
            if (held_count == 2) push_decoded(plain_byte(held_bytes[1]), 1'b1);
            if (step_count == 0) push_decoded(8'h00, 1'b0);
            expected_bytes[expected_bytes.size() - 1].last = 1'b1;
            held_count    = 0;
            held_bytes[0] = '0;
            held_bytes[1] = '0;
        end
    endfunction

    // compare one decoded item with the oldest prediction
    function void check_decoded_byte(qpd_pkg::t_res got);
        qpd_pkg::t_res exp_r;
        if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected item: data %h valid %b last %b",
                     $time, got.data, got.valid, got.last);
            errors++;
            return;
        end
        exp_r = expected_bytes.pop_front();
        if (got.data !== exp_r.data || got.valid !== exp_r.valid
                || got.last !== exp_r.last) begin
            $display("%0t: mismatch: expected data %h valid %b last %b, %s",
                     $time, exp_r.data, exp_r.valid, exp_r.last,
                     $sformatf("got data %h valid %b last %b",
                               got.data, got.valid, got.last));
            errors++;
        end
    endfunction

endclass

module tb_quoted_printable_decoder;

    timeunit 1ns;
    timeprecision 1ps;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;    // [7:0] data_byte
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;    // [7:0] out_byte
    logic       m_tuser;    // [0] byte_valid
    logic       m_tlast;

    qp_scoreboard sb = new();

    int unsigned send_idle_pct;
    int unsigned ready_idle_pct;
    int unsigned items_sent;

    quoted_printable_decoder u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 i_clk = ~i_clk;

    // receiver stalls at random
    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(0, 99) >= ready_idle_pct);
    end

    // both handshakes seen at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && s_tready) sb.note_encoded_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                sb.check_decoded_byte('{data: m_tdata, valid: m_tuser, last: m_tlast});
            end
        end
    end

    // present one encoded item, with random idle cycles ahead of it
    task automatic send_item(input logic [7:0] b, input logic eom);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eom;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] random_hex_char();
        int unsigned v;
        v = $urandom_range(0, 15);
        if (v < 10) return 8'("0" + v);
        return $urandom_range(0, 1) ? 8'("A" + v - 10) : 8'("a" + v - 10);
    endfunction

    // one message of random tokens, on average half of them well-formed escapes
    task automatic send_random_message();
        logic [7:0]  msg[$];
        int unsigned n_tok;
        int unsigned pick;
        n_tok = $urandom_range(1, 8);
        repeat (n_tok) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                msg.push_back("=");
                msg.push_back(random_hex_char());
                msg.push_back(random_hex_char());
            end else if (pick < 50) begin
                msg.push_back("=");
                msg.push_back(8'h0D);
                msg.push_back(8'h0A);
            end else if (pick < 60) begin
                msg.push_back("_");
            end else if (pick < 70) begin
                msg.push_back(8'($urandom_range(32, 126)));
            end else if (pick < 82) begin
                msg.push_back(8'($urandom_range(0, 255)));
            end else if (pick < 92) begin
                // broken escape
                msg.push_back("=");
                msg.push_back(8'($urandom_range(0, 255)));
                msg.push_back(8'($urandom_range(0, 255)));
            end else begin
                // half escape or lone line-break byte after '='
                msg.push_back("=");
                msg.push_back($urandom_range(0, 1) ? random_hex_char() : 8'h0D);
                msg.push_back($urandom_range(0, 1) ? 8'h0A : 8'($urandom_range(0, 255)));
            end
        end
        // sometimes cut one or two bytes off the end, which may stop the message inside an escape
        if (msg.size() > 2 && $urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 2)) void'(msg.pop_back());
        end
        foreach (msg[k]) send_item(msg[k], k == msg.size() - 1);
    endtask

    initial begin
        logic [8:0] directed[];
        int unsigned drain;
        // {eom, byte}
        directed = '{
            9'h03D, 9'h039, 9'h061, 9'h03D, 9'h046, 9'h030, 9'h05F, 9'h000,
            9'h0FF, 9'h03D, 9'h00D, 9'h10A,
            9'h03D, 9'h047, 9'h031, 9'h03D, 9'h00D, 9'h078, 9'h03D, 9'h080,
            9'h035, 9'h00A, 9'h13D,
            9'h03D, 9'h15F
        };
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        m_tready       = 1'b0;
        i_rst_n        = 1'b0;
        send_idle_pct  = 38;
        ready_idle_pct = 38;
        items_sent     = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // hex pairs in both cases, underscore, extreme bytes, soft break
        // at message end, broken escapes, lone '=' and '=' '_' at the end
        foreach (directed[k]) send_item(directed[k][7:0], directed[k][8]);

        while (items_sent < 315) begin
            if (items_sent >= 130 && items_sent < 230) begin
                send_idle_pct  = 0;
                ready_idle_pct = 0;
            end else begin
                send_idle_pct  = 38;
                ready_idle_pct = 38;
            end
            send_random_message();
        end
        s_tvalid       <= 1'b0;
        ready_idle_pct = 38;

        while (sb.expected_bytes.size() != 0) @(posedge i_clk);
        drain = 0;
        while (drain < 20) begin
            @(posedge i_clk);
            drain++;
        end

        if (sb.errors == 0 && sb.expected_bytes.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2ms;
        $display("%0t: timeout, %0d items still expected", $time, sb.expected_bytes.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[sim.f]
rtl/qpd_pkg.sv
rtl/qpd_decode.sv
rtl/qpd_out_buf.sv
rtl/quoted_printable_decoder.sv
tb/tb_quoted_printable_decoder.sv
